### sv/epwm_pkg.sv
// Shared types, codes and default constants for the ESC pulse generator.
package epwm_pkg;

  localparam int PULSE_W    = 12;
  localparam int THRUST_W   = 16;
  localparam int CMD_W      = 8;
  localparam int PERIOD_W   = 12;
  localparam int SETTLE_W   = 22;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 22;
  localparam int IDX_W      = 2;
  localparam int LEVELS_W   = 4;

  localparam int FULL_SCALE = 65535;

  localparam int NUM_MOTORS_DEF   = 4;
  localparam int PULSE_MIN_US_DEF = 1000;
  localparam int PULSE_MAX_US_DEF = 2000;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 12'd2500;
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 22'd2000000;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_CALIB = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  localparam logic [CMD_W-1:0] CMD_START  = 8'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 8'd2;
  localparam logic [CMD_W-1:0] CMD_ABORT  = 8'd3;

  typedef struct packed {
    logic                calib_active;
    logic [THRUST_W-1:0] ratio;
    logic [LEVELS_W-1:0] pwm_levels;
  } result_t;

endpackage

### sv/epwm_conv.sv
// Thrust to pulse width mapping and its clamped inverse; the inverse uses a constant reciprocal.
module epwm_conv #(
  parameter int PulseMin = epwm_pkg::PULSE_MIN_US_DEF,
  parameter int PulseMax = epwm_pkg::PULSE_MAX_US_DEF
) (
  input  logic [epwm_pkg::THRUST_W-1:0] thrust_i,
  input  logic [epwm_pkg::PULSE_W-1:0]  pulse_i,
  output logic [epwm_pkg::PULSE_W-1:0]  pulse_o,
  output logic [epwm_pkg::THRUST_W-1:0] ratio_o
);
  import epwm_pkg::*;

  localparam int Span  = PulseMax - PulseMin;
  localparam int SpanW = (Span > 1) ? $clog2(Span + 1) : 1;
  localparam int ProdW = THRUST_W + SpanW;

  // ceil(65535 * 2^24 / span): exact floor for any d * span below 2^24
  localparam int RecipShift = 24;
  localparam longint unsigned Recip =
    ((longint'(FULL_SCALE) << RecipShift) + longint'(Span) - 1) / longint'(Span);
  localparam int RecipW = $clog2(Recip + 1);
  localparam logic [RecipW-1:0] RecipV = RecipW'(Recip);

  // forward: PulseMin + thrust * span / 65535
  logic [ProdW-1:0]    prod;
  logic [ProdW-17:0]   q0;
  logic [THRUST_W:0]   rem_sum;
  logic                corr;

  assign prod    = ProdW'(thrust_i) * ProdW'(Span);
  assign q0      = prod[ProdW-1:THRUST_W];
  // x = q0 * 65536 + b, so x - q0 * 65535 = q0 + b, below twice 65535
  assign rem_sum = {1'b0, prod[THRUST_W-1:0]} + (THRUST_W+1)'(q0);
  assign corr    = (rem_sum >= (THRUST_W+1)'(FULL_SCALE));
  assign pulse_o = PULSE_W'(PulseMin) + PULSE_W'(q0) + PULSE_W'(corr);

  // inverse: (pulse - PulseMin) * 65535 / span, clamped
  logic [PULSE_W-1:0]        diff;
  logic [PULSE_W+RecipW-1:0] prod2;

  assign diff  = pulse_i - PULSE_W'(PulseMin);
  assign prod2 = (PULSE_W+RecipW)'(diff) * (PULSE_W+RecipW)'(RecipV);

  always_comb begin
    if (pulse_i <= PULSE_W'(PulseMin)) begin
      ratio_o = '0;
    end else if (pulse_i >= PULSE_W'(PulseMax)) begin
      ratio_o = THRUST_W'(FULL_SCALE);
    end else begin
      ratio_o = prod2[RecipShift +: THRUST_W];
    end
  end

endmodule

### sv/epwm_skid.sv
// Two-entry output stage: result register plus skid register.
module epwm_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  epwm_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output epwm_pkg::result_t out_data_o
);
  import epwm_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, skid_data_q;
  logic    in_xfer, out_pop;

  assign in_ready_o  = ~skid_valid_q;
  assign in_xfer     = in_valid_i & in_ready_o;
  assign out_pop     = out_valid_q & out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_d = 1'b0;
      end
    end else begin
      out_valid_d  = in_xfer | (out_valid_q & ~out_pop);
      skid_valid_d = in_xfer & out_valid_q & ~out_pop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_data_q <= skid_data_q;
      end
    end else if (in_xfer) begin
      if (!out_valid_q || out_pop) begin
        out_data_q <= in_data_i;
      end else begin
        skid_data_q <= in_data_i;
      end
    end
  end

endmodule

### sv/esc_pwm_with_calibration.sv
// Top level of the multi-channel ESC pulse generator with calibration sequence.
// Output: the result of an item is registered before it appears on m_axis.
// Throughput: one item per cycle while skid is empty; state updates in a single
// pass, a skid stage keeps input flowing while one result waits downstream.
// Reset: asynchronous, registers return to defaults at once; no clearing pass.
module esc_pwm_with_calibration #(
  parameter int NUM_MOTORS   = epwm_pkg::NUM_MOTORS_DEF,
  parameter int PULSE_MIN_US = epwm_pkg::PULSE_MIN_US_DEF,
  parameter int PULSE_MAX_US = epwm_pkg::PULSE_MAX_US_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [epwm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [epwm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] motor_index, [17:2] thrust, [25:18] calib_command, [31:26] zero
  input  logic [31:0]                     s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [3:0] pwm_levels, [19:4] ratio, [20] calib_active, [23:21] zero
  output logic [23:0]                     m_axis_tdata
);
  import epwm_pkg::*;

  localparam int MI_W  = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int EXT_W = (MI_W > IDX_W) ? MI_W : IDX_W;

  logic [PERIOD_W-1:0] period_q;
  logic [SETTLE_W-1:0] settle_ticks_q;

  logic [PERIOD_W-1:0] count_q, count_d;
  logic [PULSE_W-1:0]  prog_q [NUM_MOTORS];
  logic [PULSE_W-1:0]  prog_d [NUM_MOTORS];
  logic [PULSE_W-1:0]  cmp_q  [NUM_MOTORS];
  logic [PULSE_W-1:0]  cmp_d  [NUM_MOTORS];
  logic [NUM_MOTORS-1:0] lvl_q, lvl_d;
  logic                calib_q, calib_d;
  logic [SETTLE_W-1:0] settle_q, settle_d;

  op_e                 op;
  logic [IDX_W-1:0]    motor_index;
  logic [THRUST_W-1:0] thrust;
  logic [CMD_W-1:0]    calib_command;
  logic [EXT_W-1:0]    idx_ext;
  logic [MI_W-1:0]     mi;
  logic                in_range;
  logic                in_xfer;

  logic [PULSE_W-1:0]  set_pulse;
  logic [PULSE_W-1:0]  rd_pulse;
  logic [THRUST_W-1:0] rd_ratio;

  logic [PERIOD_W-1:0] per_eff;
  logic [PERIOD_W:0]   count_inc;
  logic                count_zero;

  result_t             res;
  result_t             out_res;

  assign op            = op_e'(s_axis_tuser);
  assign motor_index   = s_axis_tdata[1:0];
  assign thrust        = s_axis_tdata[17:2];
  assign calib_command = s_axis_tdata[25:18];
  assign idx_ext       = EXT_W'(motor_index);
  assign mi            = idx_ext[MI_W-1:0];
  assign in_range      = (int'(motor_index) < NUM_MOTORS);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign rd_pulse      = prog_q[mi];

  epwm_conv #(
    .PulseMin (PULSE_MIN_US),
    .PulseMax (PULSE_MAX_US)
  ) u_conv (
    .thrust_i (thrust),
    .pulse_i  (rd_pulse),
    .pulse_o  (set_pulse),
    .ratio_o  (rd_ratio)
  );

  // zero period behaves as a period of one
  assign per_eff    = (period_q == '0) ? PERIOD_W'(1) : period_q;
  assign count_inc  = {1'b0, count_q} + (PERIOD_W+1)'(1);
  assign count_zero = (count_q == '0);

  always_comb begin
    count_d  = count_q;
    prog_d   = prog_q;
    cmp_d    = cmp_q;
    lvl_d    = lvl_q;
    calib_d  = calib_q;
    settle_d = settle_q;
    res.ratio = '0;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < NUM_MOTORS; i++) begin
          cmp_d[i] = count_zero ? prog_q[i] : cmp_q[i];
          // low wins over high when the compare matches count zero
          lvl_d[i] = (count_zero | lvl_q[i]) & (cmp_d[i] != count_q);
        end
        count_d = (count_inc >= {1'b0, per_eff}) ? '0 : count_inc[PERIOD_W-1:0];
        if (settle_q != '0) begin
          settle_d = settle_q - SETTLE_W'(1);
          if (settle_q == SETTLE_W'(1)) begin
            calib_d = 1'b0;
          end
        end
      end
      OP_SET: begin
        if (!calib_q && in_range) begin
          prog_d[mi] = set_pulse;
        end
      end
      OP_CALIB: begin
        case (calib_command)
          CMD_START: begin
            calib_d  = 1'b1;
            settle_d = '0;
            for (int i = 0; i < NUM_MOTORS; i++) prog_d[i] = PULSE_W'(PULSE_MAX_US);
          end
          CMD_FINISH: begin
            if (calib_q) begin
              for (int i = 0; i < NUM_MOTORS; i++) prog_d[i] = PULSE_W'(PULSE_MIN_US);
              settle_d = settle_ticks_q;
              calib_d  = (settle_ticks_q != '0);
            end
          end
          CMD_ABORT: begin
            calib_d  = 1'b0;
            settle_d = '0;
            for (int i = 0; i < NUM_MOTORS; i++) prog_d[i] = PULSE_W'(PULSE_MIN_US);
          end
          default: ;
        endcase
      end
      OP_READ: begin
        if (in_range) begin
          res.ratio = rd_ratio;
        end
      end
      default: ;
    endcase
    res.calib_active = calib_d;
    res.pwm_levels   = '0;
    for (int i = 0; i < LEVELS_W; i++) begin
      if (i < NUM_MOTORS) begin
        res.pwm_levels[i] = lvl_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q       <= PERIOD_RESET;
      settle_ticks_q <= SETTLE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PERIOD: period_q       <= cfg_wdata_i[PERIOD_W-1:0];
        REG_SETTLE: settle_ticks_q <= cfg_wdata_i[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      lvl_q    <= '0;
      calib_q  <= 1'b0;
      settle_q <= '0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        prog_q[i] <= PULSE_W'(PULSE_MIN_US);
        cmp_q[i]  <= PULSE_W'(PULSE_MIN_US);
      end
    end else if (in_xfer) begin
      count_q  <= count_d;
      lvl_q    <= lvl_d;
      calib_q  <= calib_d;
      settle_q <= settle_d;
      prog_q   <= prog_d;
      cmp_q    <= cmp_d;
    end
  end

  epwm_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {3'b000, out_res};

endmodule
